FILE: rtl/assert_macros.svh
// Assertion helpers shared by the mailbox RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("mailbox assertion failed");

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("mailbox forbidden condition seen");

`endif

FILE: rtl/tmfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox package
// Types, sizes and codes shared by the task mailbox queue.
// ----------------------------------------------------------------------------
package tmfq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TASK_COUNT  = 8;
    localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] BROADCAST_ID = 8'hFF;
    localparam logic [7:0] ANY_KIND     = 8'h00;

    localparam logic       REQ_SEND = 1'b0;
    localparam logic       REQ_RECV = 1'b1;

    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_NO_MATCH   = 2'd1;
    localparam logic [1:0] STAT_FULL       = 2'd2;
    localparam logic [1:0] STAT_BAD_TARGET = 2'd3;

    typedef struct packed {
        logic [7:0]         sender;
        logic [7:0]         dest;
        logic [7:0]         kind;
        logic signed [31:0] payload;
    } t_entry;

    // Receive filter handed to every cell.
    typedef struct packed {
        logic [7:0] own;
        logic [7:0] kind;
    } t_filter;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

endpackage

FILE: rtl/tmfq_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmfq_req_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [7:0]         own_task;
    logic [7:0]         dest_task;
    logic [7:0]         type_code;
    logic signed [31:0] payload_in;

    modport source (output valid, req_type, own_task, dest_task, type_code, payload_in,
                    input ready);
    modport sink   (input valid, req_type, own_task, dest_task, type_code, payload_in,
                    output ready);
endinterface

interface tmfq_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] payload_out;
    logic [7:0]         sender_task;

    modport source (output valid, status, payload_out, sender_task, input ready);
    modport sink   (input valid, status, payload_out, sender_task, output ready);
endinterface

FILE: rtl/task_mailbox_filtered_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Task mailbox with filtered receive
// Ordered message queue built from a chain of cells; receive picks the oldest
// message that matches the asking task and type and closes the gap.
// ----------------------------------------------------------------------------
//  Channel   Dir  Beat contents
//  i_req     in   req_type, own_task, dest_task, type_code, payload_in
//  o_rsp     out  status, payload_out, sender_task
//
//  Each request has an accept cycle and an execute state in which the match
//  ripples through the cell chain and the queue updates.
//  Reset clears the fill count, the state and the response valid flag.
//  A stalled response holds the execute state; the next request is taken
//  once the queue update is done, while the response may still wait.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module task_mailbox_filtered_queue
    import tmfq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    tmfq_req_if.sink   i_req,
    tmfq_rsp_if.source o_rsp
);

    t_state             r_state;
    t_state             n_state;
    logic               r_req_type;
    logic [7:0]         r_own;
    logic [7:0]         r_target;
    logic [7:0]         r_kind;
    logic signed [31:0] r_payload;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  n_fill;
    logic               r_out_valid;
    logic [1:0]         r_status;
    logic signed [31:0] r_out_payload;
    logic [7:0]         r_out_sender;

    logic               w_in_ready;
    logic               w_accept;
    logic               w_commit;
    logic               w_bad_target;
    logic               w_full;
    logic               w_send_ok;
    logic               w_recv_ok;
    logic [1:0]         w_status;
    t_filter            w_filter;
    t_entry             w_new;
    t_entry             w_sel;
    logic [QUEUE_DEPTH:0]   w_found;
    logic [QUEUE_DEPTH-1:0] w_hit;
    t_entry             w_entry [QUEUE_DEPTH];

    assign w_filter.own  = r_own;
    assign w_filter.kind = r_kind;

    assign w_new.sender  = r_own;
    assign w_new.dest    = r_target;
    assign w_new.kind    = r_kind;
    assign w_new.payload = r_payload;

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry w_next;
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_entry[g];
        end else begin : g_mid
            assign w_next = w_entry[g+1];
        end

        tmfq_cell u_cell (
            .i_clk    (i_clk),
            .i_live   (FILL_W'(g) < r_fill),
            .i_filter (w_filter),
            .i_found  (w_found[g]),
            .i_remove (w_recv_ok),
            .i_write  (w_send_ok && (r_fill == FILL_W'(g))),
            .i_new    (w_new),
            .i_next   (w_next),
            .o_found  (w_found[g+1]),
            .o_hit    (w_hit[g]),
            .o_entry  (w_entry[g])
        );
    end

    // At most one cell hits, so an AND-OR picks the claimed entry.
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_sel = w_sel | (w_entry[k] & {$bits(t_entry){w_hit[k]}});
        end
    end

    assign w_bad_target = (r_target >= 8'(TASK_COUNT)) && (r_target != BROADCAST_ID);
    assign w_full       = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign w_send_ok    = w_commit && (r_req_type == REQ_SEND) && !w_bad_target && !w_full;
    assign w_recv_ok    = w_commit && (r_req_type == REQ_RECV) && w_found[QUEUE_DEPTH];

    always_comb begin
        if (r_req_type == REQ_SEND) begin
            if (w_bad_target) begin
                w_status = STAT_BAD_TARGET;
            end else if (w_full) begin
                w_status = STAT_FULL;
            end else begin
                w_status = STAT_OK;
            end
        end else if (w_found[QUEUE_DEPTH]) begin
            w_status = STAT_OK;
        end else begin
            w_status = STAT_NO_MATCH;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        w_in_ready = 1'b0;
        w_commit   = 1'b0;
        case (r_state)
            ST_IDLE: w_in_ready = 1'b1;
            ST_EXEC: w_commit   = !r_out_valid || o_rsp.ready;
            default: begin
                w_in_ready = 1'b0;
                w_commit   = 1'b0;
            end
        endcase
    end

    assign w_accept = i_req.valid && w_in_ready;

    always_comb begin
        n_fill = r_fill;
        if (w_send_ok) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (w_recv_ok) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req_type <= i_req.req_type;
            r_own      <= i_req.own_task;
            r_target   <= i_req.dest_task;
            r_kind     <= i_req.type_code;
            r_payload  <= i_req.payload_in;
        end
        if (w_commit) begin
            r_status      <= w_status;
            r_out_payload <= w_recv_ok ? w_sel.payload : 32'sd0;
            r_out_sender  <= w_recv_ok ? w_sel.sender : 8'd0;
        end
    end

    assign i_req.ready       = w_in_ready;
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.payload_out = r_out_payload;
    assign o_rsp.sender_task = r_out_sender;

    `ASSERT_NEVER(a_fill_range, i_clk, i_rst_n, r_fill > FILL_W'(QUEUE_DEPTH))
    `ASSERT_CLK(a_single_hit, i_clk, i_rst_n, $onehot0(w_hit))
    `ASSERT_CLK(a_recv_shrinks, i_clk, i_rst_n, w_recv_ok |=> r_fill == $past(r_fill) - FILL_W'(1))
    `ASSERT_CLK(a_accept_exec, i_clk, i_rst_n, w_accept |=> (r_state == ST_EXEC))
    `ASSERT_CLK(a_commit_valid, i_clk, i_rst_n, w_commit |=> r_out_valid)

endmodule

FILE: rtl/tmfq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox cell
// Holds one queue slot, checks it against the receive filter and takes the
// entry of its right neighbor when a message at or before it is removed.
// ----------------------------------------------------------------------------
module tmfq_cell
    import tmfq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_live,
    input  t_filter i_filter,
    input  logic    i_found,
    input  logic    i_remove,
    input  logic    i_write,
    input  t_entry  i_new,
    input  t_entry  i_next,
    output logic    o_found,
    output logic    o_hit,
    output t_entry  o_entry
);

    t_entry r_entry;
    t_entry n_entry;
    logic   w_addr_ok;
    logic   w_kind_ok;
    logic   w_match;

    assign w_addr_ok = (r_entry.dest == i_filter.own) || (r_entry.dest == BROADCAST_ID);
    assign w_kind_ok = (i_filter.kind == ANY_KIND) || (r_entry.kind == i_filter.kind);
    assign w_match   = i_live && w_addr_ok && w_kind_ok;

    // Only the first matching cell along the chain claims the message.
    assign o_hit   = w_match && !i_found;
    assign o_found = i_found || w_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_write) begin
            n_entry = i_new;
        end else if (i_remove && o_found) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
